>>> sv/tjd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tjd_pkg: shared constants for the tetrahedral Jacobian determinant block
// Operation codes and default sizes.
// ----------------------------------------------------------------------------
package tjd_pkg;
    localparam int VERTEX_DEPTH_D    = 1024;
    localparam int COORD_BITS_D      = 16;
    localparam int RATIO_FRAC_BITS_D = 16;
    localparam int IN_COORD_W        = 16;
    localparam int INDEX_W           = 10;
    localparam int RATIO_W           = 32;
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;
endpackage
`default_nettype wire

>>> sv/tjd_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tjd_ram: generic single-port RAM
// One access per cycle, read data registered; a write also returns the old word.
// ----------------------------------------------------------------------------
module tjd_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

>>> sv/tjd_det.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tjd_det: 3x3 determinant of edge vectors
// Takes origin then three corners serially; after the last corner it forms
// the cofactors, then the first cofactor product, then the other two, then
// registers the sum as the determinant.
// ----------------------------------------------------------------------------
module tjd_det
    import tjd_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_D,
    parameter int DET_W      = 3 * (COORD_BITS + 1) + 3
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_vld,
    input  wire logic [1:0]              i_slot,
    input  wire logic [3*COORD_BITS-1:0] i_vtx,
    output logic                         o_vld,
    output logic signed [DET_W-1:0]      o_det
);
    localparam int EW = COORD_BITS + 1;
    localparam int CW = 2 * EW + 1;
    localparam int PW = CW + EW;

    logic signed [COORD_BITS-1:0] r_ox, r_oy, r_oz;
    logic signed [EW-1:0]         r_e [9];
    logic signed [CW-1:0]         r_cof [3];
    logic signed [PW-1:0]         r_prod [3];
    logic [3:0]                   r_seq;
    logic signed [COORD_BITS-1:0] w_x, w_y, w_z;
    logic signed [DET_W-1:0]      n_det;

    assign w_x = i_vtx[3*COORD_BITS-1:2*COORD_BITS];
    assign w_y = i_vtx[2*COORD_BITS-1:COORD_BITS];
    assign w_z = i_vtx[COORD_BITS-1:0];
    assign n_det = DET_W'(r_prod[0]) - DET_W'(r_prod[1]) + DET_W'(r_prod[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq <= '0;
            o_vld <= 1'b0;
        end else begin
            o_vld <= 1'b0;
            r_seq <= {r_seq[2:0], 1'b0};
            if (i_vld && i_slot == 2'd3) begin
                r_seq <= 4'b0001;
            end
            if (r_seq[3]) begin
                o_vld <= 1'b1;
                o_det <= n_det;
            end
        end
        if (i_vld) begin
            if (i_slot == 2'd0) begin
                r_ox <= w_x;
                r_oy <= w_y;
                r_oz <= w_z;
            end else begin
                r_e[3*(i_slot-2'd1)]   <= EW'(w_x) - EW'(r_ox);
                r_e[3*(i_slot-2'd1)+1] <= EW'(w_y) - EW'(r_oy);
                r_e[3*(i_slot-2'd1)+2] <= EW'(w_z) - EW'(r_oz);
            end
        end
        // cofactors, then one product each
        if (r_seq[0]) begin
            r_cof[0] <= CW'(r_e[4]) * CW'(r_e[8]) - CW'(r_e[5]) * CW'(r_e[7]);
            r_cof[1] <= CW'(r_e[3]) * CW'(r_e[8]) - CW'(r_e[5]) * CW'(r_e[6]);
            r_cof[2] <= CW'(r_e[3]) * CW'(r_e[7]) - CW'(r_e[4]) * CW'(r_e[6]);
        end
        if (r_seq[1]) begin
            r_prod[0] <= PW'(r_e[0]) * PW'(r_cof[0]);
        end
        if (r_seq[2]) begin
            r_prod[1] <= PW'(r_e[1]) * PW'(r_cof[1]);
            r_prod[2] <= PW'(r_e[2]) * PW'(r_cof[2]);
        end
    end
endmodule
`default_nettype wire

>>> sv/tjd_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tjd_div: signed ratio with saturation
// Restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tjd_div
    import tjd_pkg::*;
#(
    parameter int DET_W           = 54,
    parameter int RATIO_FRAC_BITS = RATIO_FRAC_BITS_D
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_start,
    input  wire logic signed [DET_W-1:0] i_num,
    input  wire logic signed [DET_W-1:0] i_den,
    output logic                        o_done,
    output logic signed [RATIO_W-1:0]   o_ratio,
    output logic                        o_degen
);
    localparam int NW = DET_W + RATIO_FRAC_BITS;
    localparam int CNT_W = $clog2(NW + 1);

    logic [NW-1:0]    r_num, r_q;
    logic [DET_W:0]   r_rem;
    logic [DET_W-1:0] r_den;
    logic             r_neg, r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic [DET_W:0]   w_sh, w_sub;
    logic [NW-1:0]    w_q;
    logic             w_big;

    assign w_sh  = {r_rem[DET_W-1:0], r_num[NW-1]};
    assign w_sub = w_sh - {1'b0, r_den};
    assign w_q   = {r_q[NW-2:0], ~w_sub[DET_W]};
    assign w_big = r_neg ? (w_q > NW'(33'h80000000)) : (w_q > NW'(32'h7FFFFFFF));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                if (i_den == '0) begin
                    o_done  <= 1'b1;
                    o_ratio <= '0;
                    o_degen <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                    r_cnt  <= CNT_W'(NW);
                    r_rem  <= '0;
                    r_q    <= '0;
                    r_neg  <= i_num[DET_W-1] ^ i_den[DET_W-1];
                    r_den  <= i_den[DET_W-1] ? -i_den : i_den;
                    r_num  <= {(i_num[DET_W-1] ? -i_num : i_num),
                               RATIO_FRAC_BITS'(0)};
                end
            end else if (r_busy) begin
                r_rem <= w_sub[DET_W] ? w_sh : w_sub;
                r_q   <= w_q;
                r_num <= {r_num[NW-2:0], 1'b0};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy  <= 1'b0;
                    o_done  <= 1'b1;
                    o_degen <= 1'b0;
                    if (w_big) begin
                        o_ratio <= r_neg ? 32'sh80000000 : 32'sh7FFFFFFF;
                    end else begin
                        o_ratio <= r_neg ? -RATIO_W'(w_q) : RATIO_W'(w_q);
                    end
                end
            end
        end
    end
endmodule
`default_nettype wire

>>> sv/tet_jacobian_determinant_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tet_jacobian_determinant_top: tetrahedral Jacobian determinant
// Stores reference and deformed vertices; a query returns det ratio Q16.16.
//
//   channel  | ports                                   | handshake
//   input    | i_operation, i_vertex_index, coords, ... | start & !busy
//   result   | o_volume_ratio, o_degenerate             | o_strobe, 1 cycle
//
// A load is a single write cycle and gives no result. A query reads the four
// corners from both single-port RAMs in turn; once the determinant pipelines
// finish, a registered start hands the results to the restoring divider,
// which makes one quotient bit per cycle (DET_W + RATIO_FRAC_BITS = 70), and
// one register holds the result. Busy drops together with the strobe; a
// degenerate reference skips the division steps. Reset is synchronous; RAM
// contents are undefined until written. The receiver cannot stall.
// ----------------------------------------------------------------------------
module tet_jacobian_determinant_top
    import tjd_pkg::*;
#(
    parameter int VERTEX_DEPTH    = VERTEX_DEPTH_D,
    parameter int COORD_BITS      = COORD_BITS_D,
    parameter int RATIO_FRAC_BITS = RATIO_FRAC_BITS_D
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic                  i_operation,
    input  wire logic [INDEX_W-1:0]    i_vertex_index,
    input  wire logic signed [IN_COORD_W-1:0] i_ref_x,
    input  wire logic signed [IN_COORD_W-1:0] i_ref_y,
    input  wire logic signed [IN_COORD_W-1:0] i_ref_z,
    input  wire logic signed [IN_COORD_W-1:0] i_def_x,
    input  wire logic signed [IN_COORD_W-1:0] i_def_y,
    input  wire logic signed [IN_COORD_W-1:0] i_def_z,
    input  wire logic [INDEX_W-1:0]    i_corner_a,
    input  wire logic [INDEX_W-1:0]    i_corner_b,
    input  wire logic [INDEX_W-1:0]    i_corner_c,
    input  wire logic [INDEX_W-1:0]    i_corner_d,
    output logic                       o_strobe,
    output logic signed [RATIO_W-1:0]  o_volume_ratio,
    output logic                       o_degenerate
);
    localparam int AW    = $clog2(VERTEX_DEPTH);
    localparam int VW    = 3 * COORD_BITS;
    localparam int DET_W = 3 * (COORD_BITS + 1) + 3;

    typedef enum logic [1:0] {S_IDLE, S_READ, S_CALC} t_state;

    t_state             r_state;
    logic [INDEX_W-1:0] r_cb, r_cc, r_cd;
    logic [2:0]         r_rd;      // read slot being issued, 4 = drain
    logic               r_rvld;
    logic [1:0]         r_rslot;
    logic               r_oob_now; // corner out of range reads as zero
    logic               r_ref_got;
    logic signed [DET_W-1:0] r_dref;

    logic               w_we;
    logic [INDEX_W-1:0] w_idx;
    logic [AW-1:0]      w_addr;
    logic [VW-1:0]      w_ref_wd, w_def_wd, w_ref_rd, w_def_rd;
    logic               w_ref_vld, w_def_vld;
    logic signed [DET_W-1:0] w_ref_det, w_def_det;
    logic               w_div_done, w_div_degen;
    logic signed [RATIO_W-1:0] w_div_ratio;
    logic               w_accept;

    assign w_accept = start && !busy;
    assign busy     = (r_state != S_IDLE);
    assign w_we     = w_accept && (i_operation == OP_LOAD)
                      && (32'(i_vertex_index) < VERTEX_DEPTH);
    assign w_ref_wd = {i_ref_x[COORD_BITS-1:0], i_ref_y[COORD_BITS-1:0],
                       i_ref_z[COORD_BITS-1:0]};
    assign w_def_wd = {i_def_x[COORD_BITS-1:0], i_def_y[COORD_BITS-1:0],
                       i_def_z[COORD_BITS-1:0]};

    // address: load slot, first corner on accept, then the other three
    always_comb begin
        w_idx = i_vertex_index;
        if (w_accept && i_operation == OP_QUERY) begin
            w_idx = i_corner_a;
        end else if (r_state == S_READ) begin
            case (r_rd)
                3'd1:    w_idx = r_cb;
                3'd2:    w_idx = r_cc;
                default: w_idx = r_cd;
            endcase
        end
    end
    assign w_addr = AW'(w_idx);

    tjd_ram #(.WIDTH(VW), .DEPTH(VERTEX_DEPTH)) u_ref_ram (
        .i_clk(i_clk), .i_we(w_we), .i_addr(w_addr),
        .i_wdata(w_ref_wd), .o_rdata(w_ref_rd)
    );
    tjd_ram #(.WIDTH(VW), .DEPTH(VERTEX_DEPTH)) u_def_ram (
        .i_clk(i_clk), .i_we(w_we), .i_addr(w_addr),
        .i_wdata(w_def_wd), .o_rdata(w_def_rd)
    );

    // read data and its out-of-range flag line up in the same cycle
    tjd_det #(.COORD_BITS(COORD_BITS), .DET_W(DET_W)) u_ref_det (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_vld(r_rvld), .i_slot(r_rslot),
        .i_vtx(r_oob_now ? '0 : w_ref_rd), .o_vld(w_ref_vld), .o_det(w_ref_det)
    );
    tjd_det #(.COORD_BITS(COORD_BITS), .DET_W(DET_W)) u_def_det (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_vld(r_rvld), .i_slot(r_rslot),
        .i_vtx(r_oob_now ? '0 : w_def_rd), .o_vld(w_def_vld), .o_det(w_def_det)
    );

    tjd_div #(.DET_W(DET_W), .RATIO_FRAC_BITS(RATIO_FRAC_BITS)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_ref_got),
        .i_num(w_def_det), .i_den(r_dref),
        .o_done(w_div_done), .o_ratio(w_div_ratio), .o_degen(w_div_degen)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_rvld    <= 1'b0;
            r_ref_got <= 1'b0;
            o_strobe  <= 1'b0;
        end else begin
            o_strobe  <= 1'b0;
            r_rvld    <= 1'b0;
            r_ref_got <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (w_accept && i_operation == OP_QUERY) begin
                        r_state   <= S_READ;
                        r_rd      <= 3'd1;
                        r_rvld    <= 1'b1;
                        r_rslot   <= 2'd0;
                        r_oob_now <= 32'(i_corner_a) >= VERTEX_DEPTH;
                        r_cb      <= i_corner_b;
                        r_cc      <= i_corner_c;
                        r_cd      <= i_corner_d;
                    end
                end
                S_READ: begin
                    r_rvld    <= 1'b1;
                    r_rslot   <= r_rd[1:0];
                    r_oob_now <= 32'(w_idx) >= VERTEX_DEPTH;
                    r_rd      <= r_rd + 3'd1;
                    if (r_rd == 3'd3) begin
                        r_state <= S_CALC;
                    end
                end
                S_CALC: begin
                    // hold the divider input; both determinants land together
                    if (w_ref_vld && w_def_vld) begin
                        r_ref_got <= 1'b1;
                    end
                    if (w_div_done) begin
                        o_strobe <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
        if (w_ref_vld) begin
            r_dref <= w_ref_det;
        end
        if (w_div_done) begin
            o_volume_ratio <= w_div_ratio;
            o_degenerate   <= w_div_degen;
        end
    end
endmodule
`default_nettype wire
